[hdl/echoing_line_editor_assert.svh]
// Assertion macros used by the line editor top level.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef ECHOING_LINE_EDITOR_ASSERT_SVH
`define ECHOING_LINE_EDITOR_ASSERT_SVH
`ifndef SYNTHESIS
`define ELE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ELE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ELE_ASSERT(label, prop, msg)
`define ELE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[hdl/ele_pkg.sv]
// Package of the line editor: widths, character codes, command and result types.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ele_pkg;

	localparam int LINE_CAPACITY = 32;
	localparam int AW = $clog2(LINE_CAPACITY);
	localparam int LW = $clog2(LINE_CAPACITY + 1);
	localparam int FIFO_DEPTH = 2;
	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_DELETE = 8'h7F;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_RETURN = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	typedef struct packed {
		logic action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_byte;
		logic last;
		logic line_ready;
	} result_t;

	// Work handed from the front part to the back part.
	typedef enum logic [2:0] {
		OP_ECHO,
		OP_APPEND,
		OP_ERASE,
		OP_TAKE,
		OP_NONE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [7:0] data;
		logic [AW-1:0] addr;
		logic full;
		logic [LW-1:0] len;
		logic ready;
	} cmd_t;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} back_state_t;

endpackage
`default_nettype wire

[hdl/ele_front.sv]
// Front part: classifies each accepted transaction and keeps the line state.
// Depends on ele_pkg.
`default_nettype none
module ele_front
	import ele_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire item_t item,
	output logic push,
	output cmd_t cmd
);

	logic [LW-1:0] wpos_q;
	logic [LW-1:0] len_q;
	logic ready_q;

	logic [LW-1:0] wpos_d;
	logic [LW-1:0] len_d;
	logic ready_d;
	logic [LW-1:0] wpos_inc;

	assign wpos_inc = wpos_q + LW'(1);

	// Classify the item and work out the next line state.
	always_comb begin
		push = 1'b0;
		cmd = '{op: OP_NONE, data: CH_NUL, addr: wpos_q[AW-1:0], full: 1'b0,
			len: len_q, ready: ready_q};
		wpos_d = wpos_q;
		len_d = len_q;
		ready_d = ready_q;
		if (item.action == ACT_TAKE) begin
			push = 1'b1;
			cmd.ready = 1'b0;
			cmd.op = ready_q ? OP_TAKE : OP_NONE;
			ready_d = 1'b0;
		end else if (ready_q) begin
			// A completed line is waiting: the byte is dropped.
			push = 1'b0;
		end else if (item.rx_byte == CH_BACKSPACE || item.rx_byte == CH_DELETE) begin
			if (wpos_q != '0) begin
				push = 1'b1;
				cmd.op = OP_ERASE;
				wpos_d = wpos_q - LW'(1);
			end
		end else if (item.rx_byte == CH_NEWLINE || item.rx_byte == CH_RETURN) begin
			push = 1'b1;
			cmd.op = OP_ECHO;
			cmd.data = CH_NEWLINE;
			cmd.ready = 1'b1;
			len_d = wpos_q;
			wpos_d = '0;
			ready_d = 1'b1;
		end else if (item.rx_byte != CH_NUL) begin
			push = 1'b1;
			cmd.op = OP_APPEND;
			cmd.data = item.rx_byte;
			if (wpos_inc == LW'(LINE_CAPACITY)) begin
				// The buffer is full, so the line completes by itself.
				cmd.full = 1'b1;
				cmd.ready = 1'b1;
				len_d = wpos_inc;
				wpos_d = '0;
				ready_d = 1'b1;
			end else begin
				wpos_d = wpos_inc;
			end
		end
	end

	// Line state registers, updated on each accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			len_q <= '0;
			ready_q <= 1'b0;
		end else if (accept) begin
			wpos_q <= wpos_d;
			len_q <= len_d;
			ready_q <= ready_d;
		end
	end

endmodule
`default_nettype wire

[hdl/ele_cmd_fifo.sv]
// Short command queue between the front and back parts.
// Depends on ele_pkg.
`default_nettype none
module ele_cmd_fifo
	import ele_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire cmd_t push_cmd,
	input wire logic pop,
	output cmd_t pop_cmd,
	output logic full,
	output logic empty
);

	cmd_t entry_q [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = entry_q[rd_ptr_q];

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/ele_back.sv]
// Back part: carries out queued commands, holds the line store, emits results.
// Depends on ele_pkg.
`default_nettype none
module ele_back
	import ele_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic empty,
	input wire cmd_t pop_cmd,
	output logic pop,
	output logic strobe,
	output result_t result
);

	back_state_t state_q;
	back_state_t state_d;
	cmd_t cmd_q;
	logic [LW-1:0] step_q;
	logic [LW-1:0] step_inc;
	logic [7:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [7:0] mem [LINE_CAPACITY];

	assign step_inc = step_q + LW'(1);

	// Next state, queue pop and result selection.
	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		strobe = 1'b0;
		rd_addr = '0;
		result = '{out_kind: KIND_ECHO, out_byte: CH_NUL, last: 1'b1,
			line_ready: cmd_q.ready};
		unique case (state_q)
			B_IDLE: begin
				pop = !empty;
				if (pop) begin
					state_d = B_RUN;
				end
			end
			B_RUN: begin
				strobe = 1'b1;
				rd_addr = step_inc[AW-1:0];
				case (cmd_q.op)
					OP_ECHO: begin
						result.out_byte = cmd_q.data;
					end
					OP_APPEND: begin
						result.out_byte = (step_q == '0) ? cmd_q.data : CH_NEWLINE;
						result.last = (step_q != '0) || !cmd_q.full;
					end
					OP_ERASE: begin
						result.out_byte = (step_q == LW'(1)) ? CH_SPACE : CH_BACKSPACE;
						result.last = (step_q == LW'(2));
					end
					OP_TAKE: begin
						result.out_kind = KIND_LINE;
						result.last = (step_q == cmd_q.len);
						result.out_byte = result.last ? CH_NUL : rd_data_q;
					end
					default: begin
						result.out_kind = KIND_NONE;
					end
				endcase
				if (result.last) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= '0;
			end else if (state_q == B_RUN) begin
				step_q <= step_inc;
			end
		end
	end

	// Current command; payload only.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
	end

	// Line store: written when an append leaves the queue, read one ahead.
	always_ff @(posedge clk) begin
		if (pop && pop_cmd.op == OP_APPEND) begin
			mem[pop_cmd.addr] <= pop_cmd.data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule
`default_nettype wire

[hdl/echoing_line_editor.sv]
// Top level of the echoing line editor: front, command queue and back part.
// Depends on ele_pkg, ele_front, ele_cmd_fifo, ele_back and the assertion header.
//
// Use: drive item with start high; the transaction is taken at a clock edge
// where start is high and busy is low. action 0 carries a received byte,
// action 1 asks for the completed line. busy is high while the two-entry
// command queue is full.
// Each result appears on result for exactly one cycle with strobe high; the
// receiver must take it then, it cannot stall the block. result.last marks
// the final result of a transaction; ignored bytes give no result at all.
// The command of a taken transaction passes through the queue and the back
// part's command register before its first result. The back part takes a
// command from the queue, then gives its results back to back: an echo gives
// one result, an erase three and a take of a full line 33 (32 characters and
// the terminator), read from the line store one address ahead of the output.
// Reset clears the line state, the queue and the sequencer; the line store
// keeps no reset and its output is only used where it was written.
`default_nettype none
`include "echoing_line_editor_assert.svh"
module echoing_line_editor
	import ele_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire item_t item,
	output logic busy,
	output logic strobe,
	output result_t result
);

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t pop_cmd;
	logic fifo_full;
	logic fifo_empty;

	// A transaction is taken whenever the queue has room.
	assign busy = fifo_full;
	assign accept = start && !fifo_full;

	ele_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.push(push),
		.cmd(push_cmd)
	);

	ele_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push && accept),
		.push_cmd(push_cmd),
		.pop(pop),
		.pop_cmd(pop_cmd),
		.full(fifo_full),
		.empty(fifo_empty)
	);

	ele_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(fifo_empty),
		.pop_cmd(pop_cmd),
		.pop(pop),
		.strobe(strobe),
		.result(result)
	);

	// A missing-line answer is a single result and never reports a waiting line.
	`ELE_ASSERT(a_none_single, strobe && result.out_kind == KIND_NONE |-> result.last && !result.line_ready, "no-line result malformed")
	// Line characters are delivered back to back until the terminator.
	`ELE_ASSERT(a_line_contig, strobe && result.out_kind == KIND_LINE && !result.last |=> strobe && result.out_kind == KIND_LINE, "gap inside a line transfer")
	// The back part never pops an empty queue.
	`ELE_ASSERT(a_no_underflow, pop |-> !fifo_empty, "pop from empty command queue")

endmodule
`default_nettype wire

[tb/echoing_line_editor_tb.sv]
// Self-checking testbench of the echoing line editor: random keystrokes and line takes.
// Depends on ele_pkg and the echoing_line_editor RTL; expected output comes from a
// line-editing predictor kept in step with every accepted transaction.
`default_nettype none
module echoing_line_editor_tb;
	import ele_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_KEYS = 150;
	localparam int MAX_PRINTED = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic strobe;
	result_t result;

	// Keystrokes waiting to be sent, and echo or line bytes still to come back.
	item_t keystrokes[$];
	result_t predicted_output[$];

	// Predictor copy of the line being typed and the completed line.
	logic [7:0] line_chars[LINE_CAPACITY];
	int typed_count = 0;
	int stored_length = 0;
	bit line_waiting = 1'b0;

	int mismatch_count = 0;
	int gap_left = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	echoing_line_editor dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.strobe(strobe),
		.result(result)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		if (mismatch_count < MAX_PRINTED)
			$display("mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic result_t make_output(input logic [1:0] kind, input logic [7:0] data);
		result_t r;
		r = '0;
		r.out_kind = kind;
		r.out_byte = data;
		return r;
	endfunction

	// Applies one accepted transaction to the line state and queues what it should produce.
	task automatic apply_keystroke(input item_t k);
		result_t batch[$];
		result_t r;
		if (k.action == ACT_TAKE) begin
			if (!line_waiting) begin
				batch.push_back(make_output(KIND_NONE, CH_NUL));
			end else begin
				for (int i = 0; i < stored_length; i++)
					batch.push_back(make_output(KIND_LINE, line_chars[i]));
				batch.push_back(make_output(KIND_LINE, CH_NUL));
				line_waiting = 1'b0;
			end
		end else if (!line_waiting) begin
			if (k.rx_byte == CH_BACKSPACE || k.rx_byte == CH_DELETE) begin
				if (typed_count > 0) begin
					batch.push_back(make_output(KIND_ECHO, CH_BACKSPACE));
					batch.push_back(make_output(KIND_ECHO, CH_SPACE));
					batch.push_back(make_output(KIND_ECHO, CH_BACKSPACE));
					typed_count--;
				end
			end else if (k.rx_byte == CH_NEWLINE || k.rx_byte == CH_RETURN) begin
				batch.push_back(make_output(KIND_ECHO, CH_NEWLINE));
				stored_length = typed_count;
				typed_count = 0;
				line_waiting = 1'b1;
			end else if (k.rx_byte != CH_NUL) begin
				batch.push_back(make_output(KIND_ECHO, k.rx_byte));
				line_chars[typed_count] = k.rx_byte;
				typed_count++;
				// A full buffer completes the line on its own.
				if (typed_count >= LINE_CAPACITY) begin
					batch.push_back(make_output(KIND_ECHO, CH_NEWLINE));
					stored_length = typed_count;
					typed_count = 0;
					line_waiting = 1'b1;
				end
			end
		end
		foreach (batch[i]) begin
			r = batch[i];
			r.line_ready = line_waiting;
			r.last = (i == batch.size() - 1);
			predicted_output.push_back(r);
		end
	endtask

	task automatic push_key(input logic act, input logic [7:0] data);
		item_t k;
		k.action = act;
		k.rx_byte = data;
		keystrokes.push_back(k);
	endtask

	// Any byte that types a character rather than editing or ending the line.
	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CH_BACKSPACE || c == CH_DELETE || c == CH_NEWLINE || c == CH_RETURN);
		return c;
	endfunction

	// Mostly back-to-back transactions, some short gaps and the odd long one.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 39);
		if (r == 0) begin
			burst_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 20)
			return 0;
		if (r < 37)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Driver: a transaction is taken at an edge where start is high and busy is low.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				apply_keystroke(item);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (keystrokes.size() > 0) begin
					item <= keystrokes.pop_front();
					start <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest prediction field by field.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && strobe) begin
			if (predicted_output.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", result));
			end else begin
				want = predicted_output.pop_front();
				if (result.out_kind !== want.out_kind)
					report_mismatch($sformatf("out_kind %0d, wanted %0d",
						result.out_kind, want.out_kind));
				if (result.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %h, wanted %h",
						result.out_byte, want.out_byte));
				if (result.last !== want.last)
					report_mismatch($sformatf("last %b, wanted %b", result.last, want.last));
				if (result.line_ready !== want.line_ready)
					report_mismatch($sformatf("line_ready %b, wanted %b",
						result.line_ready, want.line_ready));
			end
		end
	end

	// Watchdog: too long without any transaction or result means the block has hung.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", predicted_output.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int random_keys;
		int line_len;
		random_keys = 0;

		// Directed: take with nothing ready, erase on an empty line, a zero byte,
		// extreme bytes, both erase codes, both line endings, bytes while a line
		// waits, an empty line and a second take.
		push_key(ACT_TAKE, 8'h5A);
		push_key(ACT_BYTE, CH_BACKSPACE);
		push_key(ACT_BYTE, CH_NUL);
		push_key(ACT_BYTE, 8'h41);
		push_key(ACT_BYTE, 8'hFF);
		push_key(ACT_BYTE, 8'h01);
		push_key(ACT_BYTE, CH_DELETE);
		push_key(ACT_BYTE, CH_BACKSPACE);
		push_key(ACT_BYTE, 8'h80);
		push_key(ACT_BYTE, CH_RETURN);
		push_key(ACT_BYTE, 8'h78);
		push_key(ACT_BYTE, CH_NEWLINE);
		push_key(ACT_TAKE, 8'hA5);
		push_key(ACT_BYTE, CH_NEWLINE);
		push_key(ACT_TAKE, 8'h00);
		push_key(ACT_TAKE, 8'hFF);

		// A line that fills the buffer, a byte that is then ignored, and its take.
		for (int i = 0; i < LINE_CAPACITY; i++)
			push_key(ACT_BYTE, rand_char());
		push_key(ACT_BYTE, rand_char());
		push_key(ACT_TAKE, 8'($urandom));

		// Random: mostly typed lines with edits, mixed with noise and broken sequences.
		while (random_keys < RANDOM_KEYS) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 7) == 0)
					line_len = $urandom_range(28, 40);
				else
					line_len = $urandom_range(0, 10);
				for (int i = 0; i < line_len; i++) begin
					if ($urandom_range(0, 7) == 0)
						push_key(ACT_BYTE, $urandom_range(0, 1) ? CH_BACKSPACE : CH_DELETE);
					else
						push_key(ACT_BYTE, rand_char());
				end
				if ($urandom_range(0, 9) != 0)
					push_key(ACT_BYTE, $urandom_range(0, 1) ? CH_RETURN : CH_NEWLINE);
				if ($urandom_range(0, 3) == 0)
					push_key(ACT_BYTE, 8'($urandom));
				push_key(ACT_TAKE, 8'($urandom));
				random_keys += line_len + 2;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					push_key(1'($urandom), 8'($urandom));
					random_keys++;
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last transaction, then for its results, then a quiet spell.
		do
			@(posedge clk);
		while (keystrokes.size() > 0 || start);
		while (predicted_output.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
+incdir+hdl
hdl/ele_pkg.sv
hdl/ele_front.sv
hdl/ele_cmd_fifo.sv
hdl/ele_back.sv
hdl/echoing_line_editor.sv
tb/echoing_line_editor_tb.sv
